### rtl/core/weighted_nll_loss_accumulator_unit_assert.svh
// Assertion macros shared by the loss accumulator modules
`ifndef WEIGHTED_NLL_LOSS_ACCUMULATOR_UNIT_ASSERT_SVH
`define WEIGHTED_NLL_LOSS_ACCUMULATOR_UNIT_ASSERT_SVH

// Implication checked on every rising clock edge outside reset
`define WNLL_ASSERT_IMP(label, clk_s, rst_s, ante, cons, msg) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication checked outside reset
`define WNLL_ASSERT_NEXT(label, clk_s, rst_s, ante, cons, msg) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/wnll_pkg.sv
// ----------------------------------------------------------------------------
// wnll_pkg
// Types, codes and constants of the weighted NLL loss accumulator.
// ----------------------------------------------------------------------------
package wnll_pkg;

    localparam int NUM_CLASSES_DEF = 256;
    localparam int PROB_BITS_DEF   = 16;
    localparam logic [31:0] LN2_Q32 = 32'd2977044472;
    localparam logic [15:0] WEIGHT_ONE = 16'd256;

    typedef enum logic [1:0] {
        CMD_LOAD   = 2'd0,
        CMD_ACCUM  = 2'd1,
        CMD_FINISH = 2'd2,
        CMD_NONE   = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        REG_IGN_EN  = 3'd0,
        REG_IGN_VAL = 3'd1,
        REG_NORM    = 3'd2,
        REG_OUTER   = 3'd3,
        REG_INNER   = 3'd4
    } reg_idx_t;

    typedef enum logic [1:0] {
        NORM_FULL   = 2'd0,
        NORM_WEIGHT = 2'd1,
        NORM_OUTER  = 2'd2,
        NORM_NONE   = 2'd3
    } norm_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOG,
        ST_NLL,     // final fraction bit settles into the -ln register
        ST_TERM,
        ST_DENOM,
        ST_DIV,
        ST_EMIT
    } state_t;

    // Controller to datapath commands
    typedef struct packed {
        logic take_item;   // register input item, start log if accumulate
        logic do_load;     // write weight table
        logic log_step;    // one squaring step of log2
        logic do_term;     // multiply and accumulate
        logic do_denom;    // set up divider
        logic div_step;    // one restoring division step
        logic do_emit;     // load output register, clear sums
    } ctl_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic log_done;
        logic div_done;
        logic out_busy;
    } ctl_stat_t;

endpackage

### rtl/core/wnll_ctrl.sv
// ----------------------------------------------------------------------------
// wnll_ctrl
// Sequencer for the loss accumulator: log iteration, accumulate, division.
// ----------------------------------------------------------------------------
module wnll_ctrl
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic [1:0]            in_cmd,
    input  logic                  in_skip,
    input  wnll_pkg::ctl_stat_t   stat,
    output logic                  in_ready,
    output wnll_pkg::ctl_cmd_t    cmd
);
    import wnll_pkg::*;

    state_t state_reg, state_next;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (in_cmd == CMD_ACCUM && !in_skip)
                        state_next = ST_LOG;
                    else if (in_cmd == CMD_FINISH)
                        state_next = ST_DENOM;
                end
            end
            ST_LOG:   if (stat.log_done) state_next = ST_NLL;
            ST_NLL:   state_next = ST_TERM;
            ST_TERM:  state_next = ST_IDLE;
            ST_DENOM: state_next = ST_DIV;
            ST_DIV:   if (stat.div_done) state_next = ST_EMIT;
            ST_EMIT:  if (!stat.out_busy) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // Outputs
    always_comb
    begin
        cmd = '0;
        in_ready = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.take_item = in_valid;
                cmd.do_load = in_valid && (in_cmd == CMD_LOAD);
            end
            ST_LOG:   cmd.log_step = 1'b1;
            ST_NLL:   cmd = '0;
            ST_TERM:  cmd.do_term = 1'b1;
            ST_DENOM: cmd.do_denom = 1'b1;
            ST_DIV:   cmd.div_step = 1'b1;
            ST_EMIT:  cmd.do_emit = !stat.out_busy;
            default:  cmd = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // Assertion helpers
    logic       is_idle;
    logic [5:0] cmd_vec;
    assign is_idle = (state_reg == ST_IDLE);
    assign cmd_vec = {cmd.take_item, cmd.log_step, cmd.do_term,
                      cmd.do_denom, cmd.div_step, cmd.do_emit};

    `include "weighted_nll_loss_accumulator_unit_assert.svh"
    `WNLL_ASSERT_IMP(a_ready_idle, clk, rst_n, in_ready, is_idle, "ready outside idle")
    `WNLL_ASSERT_NEXT(a_emit_idle, clk, rst_n, cmd.do_emit, is_idle, "emit not followed by idle")
    `WNLL_ASSERT_IMP(a_one_cmd, clk, rst_n, 1'b1, $onehot0(cmd_vec), "overlapping commands")
endmodule

### rtl/core/wnll_dp.sv
// ----------------------------------------------------------------------------
// wnll_dp
// Datapath: weight table, iterative log2, accumulators, serial divider.
// ----------------------------------------------------------------------------
module wnll_dp
#(
    parameter int NUM_CLASSES = wnll_pkg::NUM_CLASSES_DEF,
    parameter int PROB_BITS   = wnll_pkg::PROB_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  wnll_pkg::ctl_cmd_t    cmd,
    output wnll_pkg::ctl_stat_t   stat,
    input  logic [1:0]            in_cmd,
    input  logic [7:0]            in_label,
    input  logic [15:0]           in_prob,
    input  logic [15:0]           in_weight,
    input  logic                  ign_en,
    input  logic [7:0]            ign_val,
    input  logic [1:0]            norm_mode,
    input  logic [15:0]           outer_count,
    input  logic [15:0]           inner_count,
    output logic                  in_skip,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [31:0]           out_loss,
    output logic [31:0]           out_wsum,
    output logic [15:0]           out_bad
);
    import wnll_pkg::*;

    localparam int CIDX = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
    localparam logic [15:0] PTOP = 16'((32'd1 << PROB_BITS) - 32'd1);

    // Weight table with valid bits standing in for the reset value
    logic [15:0]            wmem [NUM_CLASSES];
    logic [NUM_CLASSES-1:0] wvld_reg;
    logic [15:0]            wrd_reg;
    logic                   wrd_v_reg;
    logic                   in_range;

    assign in_range = {24'd0, in_label} < NUM_CLASSES;
    assign in_skip  = (ign_en && in_label == ign_val) || !in_range;

    // Table write on load, read latched with the transaction
    always_ff @(posedge clk)
    begin
        if (cmd.do_load && in_range)
            wmem[in_label[CIDX-1:0]] <= in_weight;
        if (cmd.take_item)
            wrd_reg <= wmem[in_label[CIDX-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wvld_reg  <= '0;
            wrd_v_reg <= 1'b0;
        end
        else
        begin
            if (cmd.take_item)
                wrd_v_reg <= wvld_reg[in_label[CIDX-1:0]];
            if (cmd.do_load && in_range)
                wvld_reg[in_label[CIDX-1:0]] <= 1'b1;
        end
    end

    logic [15:0] w_cur;
    assign w_cur = wrd_v_reg ? wrd_reg : WEIGHT_ONE;

    // Probability clamp and leading-one position
    logic [15:0] p_cl;
    logic [4:0]  e_cur;
    always_comb
    begin
        p_cl = in_prob;
        if (p_cl == 16'd0) p_cl = 16'd1;
        if (p_cl > PTOP)   p_cl = PTOP;
        e_cur = '0;
        for (int k = 0; k < 16; k++)
            if (p_cl[k]) e_cur = 5'(k);
    end

    // Log2 by repeated squaring, one fraction bit a cycle
    logic [32:0] y_reg;
    logic [15:0] frac_reg;
    logic [4:0]  e_reg;
    logic [4:0]  lcnt_reg;
    logic [65:0] ysq;
    logic [34:0] ysh;

    assign ysq = {33'd0, y_reg} * {33'd0, y_reg};
    assign ysh = ysq[65:31];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            lcnt_reg <= '0;
        else if (cmd.take_item)
            lcnt_reg <= '0;
        else if (cmd.log_step)
            lcnt_reg <= lcnt_reg + 5'd1;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take_item)
        begin
            y_reg    <= 33'({17'd0, p_cl} << (5'd31 - e_cur));
            e_reg    <= e_cur;
            frac_reg <= '0;
        end
        else if (cmd.log_step)
        begin
            if (ysh[34:32] != 3'd0)
            begin
                y_reg    <= ysh[33:1];
                frac_reg <= {frac_reg[14:0], 1'b1};
            end
            else
            begin
                y_reg    <= ysh[32:0];
                frac_reg <= {frac_reg[14:0], 1'b0};
            end
        end
    end

    assign stat.log_done = (lcnt_reg == 5'd15);

    // -ln in Q5.16, registered before the weight multiply
    logic [20:0] l2;
    logic [52:0] lnp;
    logic [20:0] nll_reg;
    assign l2  = 21'(PROB_BITS << 16) - {e_reg, frac_reg};
    assign lnp = {32'd0, l2} * {21'd0, LN2_Q32};
    always_ff @(posedge clk)
        nll_reg <= 21'((lnp + 53'd2147483648) >> 32);

    // Accumulators
    logic [47:0] loss_reg;
    logic [31:0] wsum_reg;
    logic [15:0] bad_reg;
    logic [36:0] wprod;
    logic [48:0] lsum;
    logic [32:0] wadd;
    assign wprod = {21'd0, w_cur} * {16'd0, nll_reg};
    assign lsum  = {1'b0, loss_reg} + {20'd0, wprod[36:8] + 29'(wprod[7])};
    assign wadd  = {1'b0, wsum_reg} + {17'd0, w_cur};

    // Divider: 56-bit dividend, 32-bit divisor, one bit a cycle
    logic [55:0] quo_reg;
    logic [32:0] rem_reg;
    logic [31:0] den_reg;
    logic [5:0]  dcnt_reg;
    logic [32:0] rtry;
    logic [31:0] den_w;
    logic [31:0] prod_oi;

    assign prod_oi = {16'd0, outer_count} * {16'd0, inner_count};
    always_comb
    begin
        case (norm_mode)
            NORM_FULL:   den_w = prod_oi;
            NORM_WEIGHT: den_w = (wsum_reg < 32'd256) ? 32'd256 : wsum_reg;
            NORM_OUTER:  den_w = {16'd0, outer_count};
            default:     den_w = 32'd1;
        endcase
        if (den_w == 32'd0) den_w = 32'd1;
    end

    assign rtry = {rem_reg[31:0], quo_reg[55]} - {1'b0, den_reg};
    assign stat.div_done = (dcnt_reg == 6'd55);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            loss_reg  <= '0;
            wsum_reg  <= '0;
            bad_reg   <= '0;
            dcnt_reg  <= '0;
            out_valid <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
                out_valid <= 1'b0;
            if (cmd.take_item && in_cmd == CMD_ACCUM && !(ign_en && in_label == ign_val)
                && !in_range && bad_reg != 16'hFFFF)
                bad_reg <= bad_reg + 16'd1;
            if (cmd.do_term)
            begin
                loss_reg <= lsum[48] ? 48'hFFFF_FFFF_FFFF : lsum[47:0];
                wsum_reg <= wadd[32] ? 32'hFFFF_FFFF : wadd[31:0];
            end
            if (cmd.do_denom)
                dcnt_reg <= '0;
            else if (cmd.div_step)
                dcnt_reg <= dcnt_reg + 6'd1;
            if (cmd.do_emit)
            begin
                out_valid <= 1'b1;
                loss_reg  <= '0;
                wsum_reg  <= '0;
                bad_reg   <= '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.do_denom)
        begin
            den_reg <= den_w;
            rem_reg <= '0;
            quo_reg <= (norm_mode == NORM_WEIGHT) ? {loss_reg, 8'd0} : {8'd0, loss_reg};
        end
        else if (cmd.div_step)
        begin
            if (!rtry[32])
                rem_reg <= rtry;
            else
                rem_reg <= {rem_reg[31:0], quo_reg[55]};
            quo_reg <= {quo_reg[54:0], !rtry[32]};
        end
        if (cmd.do_emit)
        begin
            out_loss <= (quo_reg[55:32] != 24'd0) ? 32'hFFFF_FFFF : quo_reg[31:0];
            out_wsum <= wsum_reg;
            out_bad  <= bad_reg;
        end
    end

    assign stat.out_busy = out_valid && !out_ready;

    // Assertion helpers
    logic y_norm;
    logic sums_clr;
    assign y_norm   = (y_reg[32:31] == 2'b01);
    assign sums_clr = (loss_reg == 48'd0) && (bad_reg == 16'd0);

    `include "weighted_nll_loss_accumulator_unit_assert.svh"
    `WNLL_ASSERT_IMP(a_log_bit, clk, rst_n, cmd.log_step, y_norm, "log mantissa left [1,2)")
    `WNLL_ASSERT_IMP(a_emit_free, clk, rst_n, cmd.do_emit, !stat.out_busy, "emit while busy")
    `WNLL_ASSERT_NEXT(a_clear, clk, rst_n, cmd.do_emit, sums_clr, "sums not cleared")
endmodule

### rtl/core/weighted_nll_loss_accumulator_unit.sv
// ----------------------------------------------------------------------------
// weighted_nll_loss_accumulator_unit
// Class-weighted NLL loss accumulator with APB register port.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries commands: load class weight, accumulate position, finish.
//   m_axis carries one result per finish: normalized loss, weight total and
//   bad label count.
//   A weight load or skipped position is taken without leaving idle. A counted
//   position takes 16 squaring iterations of the log2 multiplier plus table
//   read and multiply-accumulate. A finish runs the bit-serial divider (56
//   quotient bits); the result then sits in the output register.
//   Reset restores the weight table to 1.0 via per-class valid bits, clears
//   the sums and loads register defaults; no clearing pass is needed.
//   If the receiver stalls, the block keeps taking inputs until a second
//   finish has to wait for the output register to drain.
// ----------------------------------------------------------------------------
module weighted_nll_loss_accumulator_unit
#(
    parameter int NUM_CLASSES = wnll_pkg::NUM_CLASSES_DEF,
    parameter int PROB_BITS   = wnll_pkg::PROB_BITS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,  // label[7:0], prob[23:8], weight[39:24]
    input  logic [1:0]  s_axis_tuser,  // cmd[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [79:0] m_axis_tdata   // loss[31:0], weight_total[63:32], bad[79:64]
);
    import wnll_pkg::*;

    logic        ign_en_reg;
    logic [7:0]  ign_val_reg;
    logic [1:0]  norm_reg;
    logic [15:0] outer_reg;
    logic [15:0] inner_reg;
    logic        wr;
    reg_idx_t    widx;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite;
    assign widx   = reg_idx_t'(paddr[4:2]);

    // Register file
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ign_en_reg  <= 1'b0;
            ign_val_reg <= 8'd255;
            norm_reg    <= NORM_WEIGHT;
            outer_reg   <= 16'd1;
            inner_reg   <= 16'd1;
        end
        else if (wr)
        begin
            case (widx)
                REG_IGN_EN:  ign_en_reg  <= pwdata[0];
                REG_IGN_VAL: ign_val_reg <= pwdata[7:0];
                REG_NORM:    norm_reg    <= pwdata[1:0];
                REG_OUTER:   outer_reg   <= pwdata[15:0];
                REG_INNER:   inner_reg   <= pwdata[15:0];
                default:     ;
            endcase
        end
    end

    always_comb
    begin
        case (widx)
            REG_IGN_EN:  prdata = {31'd0, ign_en_reg};
            REG_IGN_VAL: prdata = {24'd0, ign_val_reg};
            REG_NORM:    prdata = {30'd0, norm_reg};
            REG_OUTER:   prdata = {16'd0, outer_reg};
            REG_INNER:   prdata = {16'd0, inner_reg};
            default:     prdata = 32'd0;
        endcase
    end

    ctl_cmd_t  cmd;
    ctl_stat_t stat;
    logic      skip;

    wnll_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_cmd   (s_axis_tuser),
        .in_skip  (skip),
        .stat     (stat),
        .in_ready (s_axis_tready),
        .cmd      (cmd)
    );

    wnll_dp #(.NUM_CLASSES(NUM_CLASSES), .PROB_BITS(PROB_BITS)) u_dp
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .in_cmd      (s_axis_tuser),
        .in_label    (s_axis_tdata[7:0]),
        .in_prob     (s_axis_tdata[23:8]),
        .in_weight   (s_axis_tdata[39:24]),
        .ign_en      (ign_en_reg),
        .ign_val     (ign_val_reg),
        .norm_mode   (norm_reg),
        .outer_count (outer_reg),
        .inner_count (inner_reg),
        .in_skip     (skip),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .out_loss    (m_axis_tdata[31:0]),
        .out_wsum    (m_axis_tdata[63:32]),
        .out_bad     (m_axis_tdata[79:64])
    );
endmodule
